// ----- design/aging_element_table_instancer_unit_macros.svh -----
// Assertion macros for the aging element table instancer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef AGING_ELEMENT_TABLE_INSTANCER_UNIT_MACROS_SVH
`define AGING_ELEMENT_TABLE_INSTANCER_UNIT_MACROS_SVH

// same-cycle implication
`define AETIU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AETIU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/aetiu_pkg.sv -----
// Shared types, constants and the sine table for the aging element table instancer.
// No dependencies.
package aetiu_pkg;

  localparam int MAX_LIVE = 48;
  localparam int CNT_W    = $clog2(MAX_LIVE + 1);
  localparam int AGE_W    = 21;

  localparam logic [AGE_W-1:0] AGE_SAT = '1;

  // fixed-point constants
  localparam int MAX_AGE_OFS = 2621;
  localparam int MAX_AGE_K   = 91750;
  localparam int BASE_OFS    = 3277;
  localparam int BASE_K      = 19661;
  localparam int FA_OFS      = 26214;
  localparam int FA_K        = 39322;
  localparam int RAMP_K      = 104858;
  localparam int RAMP_OFS    = 19661;
  localparam int G_K         = 117965;
  localparam int X_K         = 13107;
  localparam int PHASE_K     = 417215;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;

  typedef enum logic [1:0] {
    CMD_FRAME_START = 2'd0,
    CMD_ELEMENT     = 2'd1,
    CMD_FRAME_END   = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_SIZE   = 2'd0;
  localparam logic [1:0] REG_SPREAD = 2'd1;
  localparam logic [1:0] REG_TRAIL  = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [15:0]      ident;
    logic [15:0]      position;
    logic [15:0]      amplitude;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_AGE   = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_PACK  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] dt;
  } cell_ctl_t;

  typedef struct packed {
    logic [13:0] x;
    logic [11:0] y;
    logic [15:0] scale;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } inst_res_t;

  // quarter wave of 0.3*sin, 1/65536 units
  function automatic logic [14:0] sine_q(input logic [4:0] idx);
    logic [14:0] v;
    unique case (idx)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1927;
      5'd2:    v = 15'd3836;
      5'd3:    v = 15'd5707;
      5'd4:    v = 15'd7524;
      5'd5:    v = 15'd9268;
      5'd6:    v = 15'd10923;
      5'd7:    v = 15'd12473;
      5'd8:    v = 15'd13902;
      5'd9:    v = 15'd15198;
      5'd10:   v = 15'd16347;
      5'd11:   v = 15'd17339;
      5'd12:   v = 15'd18164;
      5'd13:   v = 15'd18814;
      5'd14:   v = 15'd19283;
      5'd15:   v = 15'd19566;
      default: v = 15'd19661;
    endcase
    return v;
  endfunction

endpackage

// ----- design/aging_element_table_instancer_unit.sv -----
// Aging element table instancer: a chain of MAX_LIVE cells holding the live table.
// Frame start: ages the table. Element item: one full rotation of the chain.
// Frame end: prep, an expiry rotation and pack passes, then per instance a load, the
//   instance unit with its 17-step divider and a push that waits on output stalls,
//   and, if the table is not full, the rest of one rotation. An output register holds the last instance.
// Synchronous active-low reset empties the table and loads the register defaults.
module aging_element_table_instancer_unit
  import aetiu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_delta_time,
  input  logic [15:0]        in_element_id,
  input  logic [15:0]        in_element_pos,
  input  logic [15:0]        in_element_amp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_x_coord,
  output logic signed [11:0] out_y_coord,
  output logic [15:0]        out_scale_out,
  output logic [15:0]        out_red_level,
  output logic [15:0]        out_green_level,
  output logic [15:0]        out_blue_level,
  output logic               out_last_instance,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_AGE    = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_PREP   = 10'b00_0000_1000,
    S_EXPIRE = 10'b00_0001_0000,
    S_PACK   = 10'b00_0010_0000,
    S_LOAD   = 10'b00_0100_0000,
    S_CALC   = 10'b00_1000_0000,
    S_PUSH   = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_t;

  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(MAX_LIVE - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_LIVE);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              found_r, found_nxt;

  // latched item payload
  logic [15:0]       dt_r, id_r, pos_r, amp_r;

  // configuration registers
  logic [15:0]       size_r, spread_r, trail_r;

  // per-frame constants
  logic [16:0]       max_age_r;
  logic [14:0]       base_r;
  logic [32:0]       max_age_prod;
  logic [31:0]       base_prod;

  // chain
  entry_t            cell_q  [MAX_LIVE];
  entry_t            right_e [MAX_LIVE];
  logic              left_v  [MAX_LIVE];
  entry_t            head;
  entry_t            inject;
  cell_ctl_t         cell_ctl;
  logic              pair_any;

  // instance unit
  logic              inst_start, inst_done;
  inst_res_t         inst_res;

  // output register
  logic              out_valid_r;
  inst_res_t         out_res_r;
  logic              out_last_r;
  logic              out_load;
  logic              in_acc;
  logic [CNT_W-1:0]  last_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign head     = cell_q[0];
  assign last_idx = count_r - CNT_W'(1);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LIVE; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_v[gi] = 1'b1;
      end else begin : g_mid
        assign left_v[gi] = cell_q[gi-1].valid;
      end
      if (gi == MAX_LIVE - 1) begin : g_tail
        assign right_e[gi] = inject;
      end else begin : g_body
        assign right_e[gi] = cell_q[gi+1];
      end
      aetiu_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl),
        .left_valid (left_v[gi]),
        .right      (right_e[gi]),
        .cur        (cell_q[gi])
      );
    end
  endgenerate

  // a gap followed by a live entry means packing is not finished
  always_comb begin
    pair_any = 1'b0;
    for (int i = 0; i < MAX_LIVE - 1; i++) begin
      pair_any = pair_any | (!cell_q[i].valid & cell_q[i+1].valid);
    end
  end

  aetiu_inst u_inst (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (inst_start),
    .pos     (head.position),
    .amp     (head.amplitude),
    .age     (head.age),
    .max_age (max_age_r),
    .base    (base_r),
    .spread  (spread_r),
    .done    (inst_done),
    .res     (inst_res)
  );

  assign max_age_prod = 33'(trail_r) * 33'(MAX_AGE_K);
  assign base_prod    = 32'(size_r) * 32'(BASE_K);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    cell_ctl.op  = CELL_HOLD;
    cell_ctl.dt  = dt_r;
    inject       = head;
    inst_start   = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt  = '0;
          found_nxt = 1'b0;
          unique case (cmd_t'(in_command))
            CMD_FRAME_START: state_nxt = S_AGE;
            CMD_ELEMENT:     state_nxt = S_SCAN;
            CMD_FRAME_END:   state_nxt = S_PREP;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_AGE: begin
        cell_ctl.op = CELL_AGE;
        state_nxt   = S_IDLE;
      end
      S_SCAN: begin
        // rotate once; the first slot that matches the id or is free takes the item
        cell_ctl.op = CELL_SHIFT;
        if (!found_r && head.valid && head.ident == id_r) begin
          inject    = '{valid: 1'b1, ident: id_r, position: pos_r, amplitude: amp_r,
                        age: '0};
          found_nxt = 1'b1;
        end else if (!found_r && !head.valid) begin
          inject    = '{valid: 1'b1, ident: id_r, position: pos_r, amplitude: amp_r,
                        age: '0};
          found_nxt = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        step_nxt = step_r + CNT_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_PREP: begin
        step_nxt  = '0;
        state_nxt = S_EXPIRE;
      end
      S_EXPIRE: begin
        cell_ctl.op = CELL_SHIFT;
        if (head.valid && head.age > AGE_W'(max_age_r)) begin
          inject.valid = 1'b0;
          count_nxt    = count_r - CNT_W'(1);
        end
        step_nxt = step_r + CNT_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_PACK;
        end
      end
      S_PACK: begin
        cell_ctl.op  = CELL_PACK;
        inject.valid = 1'b0;
        if (!pair_any) begin
          step_nxt  = '0;
          state_nxt = (count_r == '0) ? S_IDLE : S_LOAD;
        end
      end
      S_LOAD: begin
        inst_start = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        if (inst_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load    = 1'b1;
          cell_ctl.op = CELL_SHIFT;
          step_nxt    = step_r + CNT_W'(1);
          if (step_r == last_idx) begin
            state_nxt = (count_r == CNT_FULL) ? S_IDLE : S_FINISH;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_FINISH: begin
        // complete the rotation so table order is restored
        cell_ctl.op = CELL_SHIFT;
        step_nxt    = step_r + CNT_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r  <= in_delta_time;
      id_r  <= in_element_id;
      pos_r <= in_element_pos;
      amp_r <= in_element_amp;
    end
    if (state_r == S_PREP) begin
      max_age_r <= 17'(MAX_AGE_OFS) + max_age_prod[32:16];
      base_r    <= 15'(BASE_OFS) + 15'(base_prod[31:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= 16'd32768;
      spread_r <= 16'd52429;
      trail_r  <= 16'd19661;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE:   size_r   <= cfg_wdata;
        REG_SPREAD: spread_r <= cfg_wdata;
        REG_TRAIL:  trail_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r  <= inst_res;
      out_last_r <= (step_r == last_idx);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x_coord       = $signed(out_res_r.x);
  assign out_y_coord       = $signed(out_res_r.y);
  assign out_scale_out     = out_res_r.scale;
  assign out_red_level     = out_res_r.red;
  assign out_green_level   = out_res_r.green;
  assign out_blue_level    = out_res_r.blue;
  assign out_last_instance = out_last_r;

endmodule

// ----- design/aetiu_cell.sv -----
// One table slot of the element chain: holds an entry, ages it, shifts or packs it.
// Depends on aetiu_pkg.
module aetiu_cell
  import aetiu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      left_valid,
  input  entry_t    right,
  output entry_t    cur
);

  entry_t             entry_r;
  entry_t             entry_nxt;
  logic [AGE_W:0]     age_sum;

  always_comb begin
    age_sum   = {1'b0, entry_r.age} + (AGE_W + 1)'(ctl.dt);
    entry_nxt = entry_r;
    unique case (ctl.op)
      CELL_AGE: begin
        entry_nxt.age = age_sum[AGE_W] ? AGE_SAT : age_sum[AGE_W-1:0];
      end
      CELL_SHIFT: begin
        entry_nxt = right;
      end
      CELL_PACK: begin
        // valid entries step left into a gap
        if (!entry_r.valid && right.valid) begin
          entry_nxt = right;
        end else if (entry_r.valid && !left_valid) begin
          entry_nxt.valid = 1'b0;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign cur = entry_r;

endmodule

// ----- design/aetiu_inst.sv -----
// Instance math for one entry: placement, scale and colour, with a bit-serial divider.
// Depends on aetiu_pkg.
module aetiu_inst
  import aetiu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [15:0]      pos,
  input  logic [15:0]      amp,
  input  logic [AGE_W-1:0] age,
  input  logic [16:0]      max_age,
  input  logic [14:0]      base,
  input  logic [15:0]      spread,
  output logic             done,
  output inst_res_t        res
);

  localparam logic [4:0] DIV_LAST = 5'd16;
  localparam logic [4:0] CYC_END  = 5'd22;

  logic        busy_r, done_r;
  logic [4:0]  cyc_r;

  logic [15:0] pos_r, amp_r;
  logic [16:0] m_r, rem_r, sh_r, q_r;

  logic [31:0] p_famp_r, p_g_r, p_base_r, p_x1_r, phase_r, p_fal_r;
  logic [32:0] p_r_r, p_b_r, p_bright_r, p_sc_r, p_lr_r, p_lg_r, p_lb_r;
  logic [15:0] famp_r, bsc_r, bright_r;
  logic [16:0] ramp_r_r, ramp_g_r, ramp_b_r, falpha_r;
  logic [45:0] p_x2_r;
  logic [1:0]  quad_r;
  logic [30:0] inq_r;
  logic [14:0] sa_r;
  logic [30:0] p_sd_r;
  logic [13:0] x_r;
  logic [11:0] y_r;
  logic [15:0] scale_r, red_r, green_r, blue_r;

  logic [15:0] mag;
  logic [16:0] dnum;
  logic [17:0] div_t, div_diff;
  logic        div_ge;
  logic [4:0]  sidx;
  logic [15:0] frac;
  logic [14:0] sa, sb;
  logic [15:0] qs;
  logic [11:0] yv;
  logic [13:0] xm;
  logic [29:0] inq_lo;

  function automatic logic [16:0] ramp_clamp(input logic [16:0] v);
    logic [16:0] d;
    d = v - 17'(RAMP_OFS);
    if (v < 17'(RAMP_OFS)) return 17'd0;
    if (d > 17'(ONE_Q16)) return 17'(ONE_Q16);
    return d;
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  always_comb begin
    mag      = pos_r[15] ? {1'b0, pos_r[14:0]} : 16'(17'(HALF_Q16) - 17'(pos_r));
    dnum     = max_age - 17'(age);
    div_t    = {rem_r, sh_r[16]};
    div_ge   = div_t >= {1'b0, m_r};
    div_diff = div_t - {1'b0, m_r};
    sidx     = inq_r[30:26];
    frac     = inq_r[25:10];
    sa       = sine_q(sidx);
    sb       = sine_q(5'(sidx + 5'd1));
    qs       = 16'(sa_r) + 16'(p_sd_r[30:16]);
    yv       = 12'((qs + 16'd8) >> 4);
    xm       = p_x2_r[45:32];
    inq_lo   = phase_r[29:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else if (busy_r) begin
      cyc_r <= cyc_r + 5'd1;
      if (cyc_r == CYC_END) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos_r <= pos;
      amp_r <= amp;
      m_r   <= max_age;
      rem_r <= {1'b0, dnum[16:1]};
      sh_r  <= {dnum[0], 16'd0};
      q_r   <= '0;
    end else if (busy_r) begin
      if (cyc_r <= DIV_LAST) begin
        rem_r <= div_ge ? div_diff[16:0] : div_t[16:0];
        sh_r  <= {sh_r[15:0], 1'b0};
        q_r   <= {q_r[15:0], div_ge};
      end
      unique case (cyc_r)
        5'd0: begin
          p_famp_r <= 32'(amp_r) * 32'(FA_K);
          p_r_r    <= 33'(pos_r) * 33'(RAMP_K);
          p_b_r    <= 33'(17'(ONE_Q16) - 17'(pos_r)) * 33'(RAMP_K);
          p_g_r    <= 32'(mag) * 32'(G_K);
          p_base_r <= 32'(base) * 32'(17'(HALF_Q16) + 17'(amp_r));
          p_x1_r   <= 32'(mag) * 32'(spread);
          phase_r  <= 32'(pos_r) * 32'(PHASE_K);
        end
        5'd1: begin
          famp_r   <= p_famp_r[31:16] + 16'(FA_OFS);
          ramp_r_r <= ramp_clamp(p_r_r[32:16]);
          ramp_g_r <= 17'(ONE_Q16) - 17'(p_g_r[31:16]);
          ramp_b_r <= ramp_clamp(p_b_r[32:16]);
          bsc_r    <= p_base_r[31:16];
          p_x2_r   <= 46'(p_x1_r) * 46'(X_K) + 46'h0000_8000_0000;
          quad_r   <= phase_r[31:30];
          // odd quadrants run the table backwards
          inq_r    <= phase_r[30] ? 31'(31'h4000_0000 - 31'(inq_lo)) : 31'(inq_lo);
        end
        5'd2: begin
          x_r <= pos_r[15] ? xm : 14'(-xm);
          if (sidx >= 5'd16) begin
            sa_r   <= sa;
            p_sd_r <= '0;
          end else begin
            sa_r   <= sa;
            p_sd_r <= 31'(sb - sa) * 31'(frac);
          end
        end
        5'd3: begin
          y_r <= quad_r[1] ? 12'(-yv) : yv;
        end
        5'd17: begin
          p_fal_r <= 32'(q_r) * 32'(FA_K);
        end
        5'd18: begin
          falpha_r <= 17'(FA_OFS) + 17'(p_fal_r[31:16]);
        end
        5'd19: begin
          p_bright_r <= 33'(famp_r) * 33'(falpha_r);
          p_sc_r     <= 33'(bsc_r) * 33'(falpha_r);
        end
        5'd20: begin
          bright_r <= sat16(p_bright_r[32:16]);
          scale_r  <= sat16(p_sc_r[32:16]);
        end
        5'd21: begin
          p_lr_r <= 33'(ramp_r_r) * 33'(bright_r);
          p_lg_r <= 33'(ramp_g_r) * 33'(bright_r);
          p_lb_r <= 33'(ramp_b_r) * 33'(bright_r);
        end
        5'd22: begin
          red_r   <= sat16(p_lr_r[32:16]);
          green_r <= sat16(p_lg_r[32:16]);
          blue_r  <= sat16(p_lb_r[32:16]);
        end
        default: begin
        end
      endcase
    end
  end

  assign done      = done_r;
  assign res.x     = x_r;
  assign res.y     = y_r;
  assign res.scale = scale_r;
  assign res.red   = red_r;
  assign res.green = green_r;
  assign res.blue  = blue_r;

endmodule

// ----- design/aetiu_checker.sv -----
// Port-level checker for the aging element table instancer, bound to the top level.
// Depends on aetiu_pkg and aging_element_table_instancer_unit_macros.svh.
`include "aging_element_table_instancer_unit_macros.svh"

module aetiu_checker
  import aetiu_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [13:0] out_x_coord,
  input logic signed [11:0] out_y_coord,
  input logic               out_last_instance
);

  `AETIU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x_coord) && $stable(out_last_instance), "stalled item changed")

  `AETIU_ASSERT_SAME(a_busy_mid_emit, out_valid && !out_last_instance, !in_ready, "input taken mid emission")

  `AETIU_ASSERT_NEXT(a_no_stray_out, in_valid && in_ready && in_command != CMD_FRAME_END, !$rose(out_valid), "item without frame end produced output")

  `AETIU_ASSERT_SAME(a_y_range, out_valid, out_y_coord <= 12'sd1229 && out_y_coord >= -12'sd1229, "y out of sine range")

endmodule

bind aging_element_table_instancer_unit aetiu_checker u_aetiu_checker (.*);
